// ----- rtl/iteration_count_piecewise_palette_unit_macros.svh -----
// shared assertion macros for the palette unit
`ifndef ITERATION_COUNT_PIECEWISE_PALETTE_UNIT_MACROS_SVH
`define ITERATION_COUNT_PIECEWISE_PALETTE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// expression must never be true out of reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

// ----- rtl/icpp_pkg.sv -----
package icpp_pkg;

    // classification of one word, made by the front end
    typedef struct packed {
        logic blk;    // count at or above the limit
        logic upper;  // count in the upper half
    } t_cls;

    localparam int NUM_CH    = 3;
    localparam int NUM_TERMS = 5;

    localparam logic [15:0] MAX_ITER_RST = 16'd1000;

    // coefficients in units of 1e-4, highest power first; red, green, blue
    localparam int LOWER_TAB [NUM_CH][NUM_TERMS] = '{
        '{0, 0, 0, 1067, 9200},
        '{0, 0, 0, 5584, 2494},
        '{0, 0, 0, -376, 282}
    };

    localparam int UPPER_TAB [NUM_CH][NUM_TERMS] = '{
        '{0, 6118, -2286, -13475, 9493},
        '{3465, -46460, 41957, -5881, 8365},
        '{-366545, 702973, -400717, 68002, -272}
    };

    // decimal coefficient to signed fixed point, round half away from zero
    function automatic longint to_fixed(input int c4, input int frac);
        longint mag;
        longint q;
        mag = (c4 < 0) ? -longint'(c4) : longint'(c4);
        q   = ((mag << frac) + 64'sd5000) / 64'sd10000;
        return (c4 < 0) ? -q : q;
    endfunction

endpackage

// ----- rtl/icpp_front.sv -----
module icpp_front #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_accept,
    input  logic [15:0]          i_max_iter,
    input  logic [15:0]          i_iter_count,
    input  logic [23:0]          i_pixel_offset,
    output logic                 o_vld,
    output icpp_pkg::t_cls       o_cls,
    output logic [FRAC_BITS-1:0] o_v,
    output logic [23:0]          o_off
);

    localparam int NS = FRAC_BITS + 2;

    logic                 r_vld [NS];
    logic                 r_blk [NS];
    logic [16:0]          r_rem [NS];
    logic [FRAC_BITS:0]   r_q   [NS];
    logic [23:0]          r_off [NS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_blk[0] <= (i_iter_count >= i_max_iter);
            r_rem[0] <= {i_iter_count, 1'b0};
            r_q[0]   <= '0;
            r_off[0] <= i_pixel_offset;
        end
    end

    // one quotient bit per stage, restoring division
    for (genvar k = 1; k < NS; k++) begin : g_div
        logic [17:0] n_d;
        logic        n_bit;
        logic [17:0] n_rem;

        always_comb begin
            if (k == 1) begin
                n_d = {1'b0, r_rem[k-1]};
            end else begin
                n_d = {r_rem[k-1], 1'b0};
            end
            n_bit = (n_d >= {2'b00, i_max_iter});
            n_rem = n_bit ? (n_d - {2'b00, i_max_iter}) : n_d;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= r_vld[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_blk[k] <= r_blk[k-1];
                r_rem[k] <= n_rem[16:0];
                r_q[k]   <= {r_q[k-1][FRAC_BITS-1:0], n_bit};
                r_off[k] <= r_off[k-1];
            end
        end
    end

    assign o_vld       = r_vld[NS-1];
    assign o_cls.blk   = r_blk[NS-1];
    assign o_cls.upper = r_q[NS-1][FRAC_BITS];
    assign o_v         = r_q[NS-1][FRAC_BITS-1:0];
    assign o_off       = r_off[NS-1];

endmodule

// ----- rtl/icpp_fifo.sv -----
`include "iteration_count_piecewise_palette_unit_macros.svh"

module icpp_fifo #(
    parameter int W = 42
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty,
    output logic         o_full
);

    logic [W-1:0] r_mem [2];
    logic         r_wp;
    logic         r_rp;
    logic [1:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    assign o_data  = r_mem[r_rp];
    assign o_empty = (r_cnt == 2'd0);
    assign o_full  = (r_cnt == 2'd2);

    `ASSERT_NEVER(a_no_overflow, i_clk, i_rst_n, i_push && o_full && !i_pop)

endmodule

// ----- rtl/icpp_back.sv -----
`include "iteration_count_piecewise_palette_unit_macros.svh"

module icpp_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_vld,
    input  icpp_pkg::t_cls       i_cls,
    input  logic [FRAC_BITS-1:0] i_v,
    input  logic [23:0]          i_off,
    output logic                 o_valid,
    output logic [7:0]           o_red,
    output logic [7:0]           o_green,
    output logic [7:0]           o_blue,
    output logic [23:0]          o_out_offset
);

    localparam int AW = FRAC_BITS + 9;
    localparam int PW = AW + FRAC_BITS + 1;
    localparam int NT = icpp_pkg::NUM_TERMS;
    localparam int NC = icpp_pkg::NUM_CH;
    localparam int LS = 2 * (NT - 1) + 1;

    logic                 r_vld [LS+1];
    logic                 r_blk [LS];
    logic                 r_up  [LS];
    logic [FRAC_BITS-1:0] r_v   [LS];
    logic [23:0]          r_off [LS];

    logic signed [AW-1:0] r_acc  [NC][NT];
    logic signed [PW-1:0] r_prod [NC][NT];
    logic signed [AW-1:0] n_acc  [NC][NT];
    logic signed [AW-1:0] n_c0   [NC];
    logic [7:0]           n_byte [NC];
    logic [7:0]           r_byte [NC];
    logic [23:0]          r_out_off;

    // horner add plus coefficient pick by segment
    always_comb begin
        for (int c = 0; c < NC; c++) begin
            n_c0[c] = i_cls.upper
                ? AW'(icpp_pkg::to_fixed(icpp_pkg::UPPER_TAB[c][0], FRAC_BITS))
                : AW'(icpp_pkg::to_fixed(icpp_pkg::LOWER_TAB[c][0], FRAC_BITS));
            n_acc[c][0] = r_acc[c][0];
            for (int i = 1; i < NT; i++) begin
                n_acc[c][i] = AW'(r_prod[c][i] >>> FRAC_BITS) + (r_up[2*i-1]
                    ? AW'(icpp_pkg::to_fixed(icpp_pkg::UPPER_TAB[c][i], FRAC_BITS))
                    : AW'(icpp_pkg::to_fixed(icpp_pkg::LOWER_TAB[c][i], FRAC_BITS)));
            end
        end
    end

    // clamp to [0,1] and scale by 255
    for (genvar c = 0; c < NC; c++) begin : g_byte
        logic [FRAC_BITS:0]   n_cl;
        logic [FRAC_BITS+8:0] n_sc;
        always_comb begin
            if (r_acc[c][NT-1] < 0) begin
                n_cl = '0;
            end else if (r_acc[c][NT-1] > (AW'(1) <<< FRAC_BITS)) begin
                n_cl = (FRAC_BITS+1)'(1) << FRAC_BITS;
            end else begin
                n_cl = r_acc[c][NT-1][FRAC_BITS:0];
            end
            n_sc      = {n_cl, 8'b0} - {8'b0, n_cl};
            n_byte[c] = r_blk[LS-1] ? 8'd0 : n_sc[FRAC_BITS+7:FRAC_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= LS; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else begin
            r_vld[0] <= i_vld;
            for (int s = 1; s <= LS; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_blk[0] <= i_cls.blk;
        r_up[0]  <= i_cls.upper;
        r_v[0]   <= i_v;
        r_off[0] <= i_off;
        for (int s = 1; s < LS; s++) begin
            r_blk[s] <= r_blk[s-1];
            r_up[s]  <= r_up[s-1];
            r_v[s]   <= r_v[s-1];
            r_off[s] <= r_off[s-1];
        end
        for (int c = 0; c < NC; c++) begin
            r_acc[c][0] <= n_c0[c];
            for (int i = 1; i < NT; i++) begin
                r_prod[c][i] <= PW'(r_acc[c][i-1])
                              * $signed({{(PW-FRAC_BITS){1'b0}}, r_v[2*i-2]});
                r_acc[c][i]  <= n_acc[c][i];
            end
            r_byte[c] <= n_byte[c];
        end
        r_out_off <= r_off[LS-1];
    end

    assign o_valid      = r_vld[LS];
    assign o_red        = r_byte[0];
    assign o_green      = r_byte[1];
    assign o_blue       = r_byte[2];
    assign o_out_offset = r_out_off;

    `ASSERT_PROP(a_latency, i_clk, i_rst_n, r_vld[0] |-> ##9 o_valid)
    `ASSERT_PROP(a_neg_clamp, i_clk, i_rst_n, (r_vld[LS-1] && r_acc[0][NT-1] < 0) |=> (o_red == 8'd0))

endmodule

// ----- rtl/iteration_count_piecewise_palette_unit.sv -----
// iteration count palette: one escape count in, one rgb pixel out
//
// input channel: an input word is taken at a rising edge with start high and
// busy low; it carries i_iter_count and i_pixel_offset. one word per clock is
// taken back to back while busy is low.
// output channel: o_valid is high for exactly one cycle with o_red, o_green,
// o_blue and o_out_offset; the receiver has no way to hold results off.
// configuration: i_cfg_we writes i_cfg_data into the max_iter register; write
// it only while no word is in flight.
// pipeline: o_valid carries the result once the word has passed the front end,
// the queue and the back end. the front end is a capture stage and a restoring
// divider with one quotient bit per stage (FRAC_BITS + 1 stages); the queue adds
// one register; the back end is a coefficient load stage, a horner pipeline with
// one multiply stage and one add stage per remaining term, then a clamp/scale
// stage. one pixel per clock is taken while busy is low.
// a two-word queue sits between front and back; the back end drains it every
// cycle, so busy only rises if the queue fills.
// reset: synchronous, active low; empties the pipeline and queue and loads
// max_iter with 1000.
module iteration_count_piecewise_palette_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] i_iter_count,
    input  logic [23:0] i_pixel_offset,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    output logic        o_valid,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic [23:0] o_out_offset
);

    localparam int QW = $bits(icpp_pkg::t_cls) + FRAC_BITS + 24;

    logic [15:0]          r_max_iter;
    logic                 fr_vld;
    icpp_pkg::t_cls       fr_cls;
    logic [FRAC_BITS-1:0] fr_v;
    logic [23:0]          fr_off;
    logic                 q_empty;
    logic                 q_full;
    logic [QW-1:0]        q_dout;
    logic                 bk_vld;
    icpp_pkg::t_cls       bk_cls;
    logic [FRAC_BITS-1:0] bk_v;
    logic [23:0]          bk_off;

    // iteration limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_iter <= icpp_pkg::MAX_ITER_RST;
        end else if (i_cfg_we) begin
            r_max_iter <= i_cfg_data;
        end
    end

    // front holds whenever the queue cannot take another word
    assign busy = q_full;

    icpp_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (!q_full),
        .i_accept       (start && !busy),
        .i_max_iter     (r_max_iter),
        .i_iter_count   (i_iter_count),
        .i_pixel_offset (i_pixel_offset),
        .o_vld          (fr_vld),
        .o_cls          (fr_cls),
        .o_v            (fr_v),
        .o_off          (fr_off)
    );

    icpp_fifo #(.W(QW)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fr_vld && !q_full),
        .i_data  ({fr_cls, fr_v, fr_off}),
        .i_pop   (!q_empty),
        .o_data  (q_dout),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    // back end takes a word from the queue every cycle one is there
    assign bk_vld = !q_empty;
    assign {bk_cls, bk_v, bk_off} = q_dout;

    icpp_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_vld        (bk_vld),
        .i_cls        (bk_cls),
        .i_v          (bk_v),
        .i_off        (bk_off),
        .o_valid      (o_valid),
        .o_red        (o_red),
        .o_green      (o_green),
        .o_blue       (o_blue),
        .o_out_offset (o_out_offset)
    );

endmodule
